// File: sv/bitmap_line_color_expander_defines.svh
// Assertion macros shared by the bitmap line color expander RTL.
// Included by files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef BITMAP_LINE_COLOR_EXPANDER_DEFINES_SVH
`define BITMAP_LINE_COLOR_EXPANDER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define BLCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define BLCE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/blce_pkg.sv
// Package for the bitmap line color expander: codes, defaults, the lane plan type
// and the pixel unpacking helpers. No dependencies.
package blce_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_PAL   = 2'd2;

  // Drawing modes.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_TRANSP = 2'd1;
  localparam logic [1:0] MODE_XOR    = 2'd2;

  // Source depth codes.
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEPTH  = 3'd0;
  localparam logic [2:0] CFG_MODE   = 3'd1;
  localparam logic [2:0] CFG_USEPAL = 3'd2;
  localparam logic [2:0] CFG_OFFSET = 3'd3;
  localparam logic [2:0] CFG_KEY    = 3'd4;

  // Parameter defaults.
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_BITS_DEF    = 16;

  // Per-position plan for one source byte: which positions are stepped and which draw.
  typedef struct packed {
    logic [7:0] span;
    logic [7:0] draw;
    logic [2:0] first_pos;
  } plan_t;

  // Mask that reduces a pixel position modulo the pixels per byte.
  function automatic logic [2:0] pos_mask(input logic [2:0] depth);
    logic [2:0] m;
    begin
      case (depth)
        DEPTH_1: m = 3'd7;
        DEPTH_2: m = 3'd3;
        DEPTH_4: m = 3'd1;
        default: m = 3'd0;
      endcase
      return m;
    end
  endfunction

  // Positions that exist within one source item at the given depth.
  function automatic logic [7:0] lane_mask(input logic [2:0] depth);
    logic [7:0] m;
    begin
      case (depth)
        DEPTH_1: m = 8'hFF;
        DEPTH_2: m = 8'h0F;
        DEPTH_4: m = 8'h03;
        default: m = 8'h01;
      endcase
      return m;
    end
  endfunction

  // Raw index of the pixel at a position, most significant pixel first.
  function automatic logic [7:0] pix_index(input logic [7:0] b, input logic [2:0] depth,
                                           input logic [2:0] pos);
    logic [7:0] idx;
    logic [2:0] sh;
    begin
      sh = {~pos[1:0], 1'b0};
      case (depth)
        DEPTH_1: idx = {7'd0, b[3'd7 - pos]};
        DEPTH_2: idx = (b >> sh) & 8'h03;
        DEPTH_4: idx = pos[0] ? {4'd0, b[3:0]} : {4'd0, b[7:4]};
        default: idx = b;
      endcase
      return idx;
    end
  endfunction

endpackage

// File: sv/blce_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the palette store.
module blce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/blce_unpack.sv
// Works out, for one source item, which pixel positions are stepped and which draw.
// Depends on blce_pkg.
module blce_unpack import blce_pkg::*; (
  input  logic [2:0]  depth_i,
  input  logic [1:0]  mode_i,
  input  logic        use_pal_i,
  input  logic [7:0]  key_i,
  input  logic [2:0]  sub_pos_i,
  input  logic [12:0] pix_left_i,
  input  logic [15:0] src_i,
  output plan_t       plan_o
);

  logic [2:0] pos0;
  logic [7:0] lanes;

  assign pos0  = sub_pos_i & pos_mask(depth_i);
  assign lanes = lane_mask(depth_i);

  // Each position is judged on its own: in the line, and drawn in the current mode.
  always_comb begin
    logic [2:0] pp;
    logic [7:0] idx;
    logic       in_rng;
    logic       drw;
    plan_o.span      = '0;
    plan_o.draw      = '0;
    plan_o.first_pos = pos0;
    for (int p = 0; p < 8; p++) begin
      pp     = 3'(p);
      idx    = pix_index(src_i[7:0], depth_i, pp);
      in_rng = (pp >= pos0) && lanes[p] && (13'(pp - pos0) < pix_left_i);
      case (depth_i) inside
        DEPTH_1: drw = (mode_i == MODE_XOR || mode_i == MODE_TRANSP) ? (idx != 8'd0) : 1'b1;
        DEPTH_2, DEPTH_4: begin
          if (mode_i == MODE_XOR) drw = 1'b0;
          else if (mode_i == MODE_TRANSP) drw = (idx != 8'd0);
          else drw = 1'b1;
        end
        DEPTH_8: begin
          if (mode_i == MODE_TRANSP) drw = use_pal_i ? (idx != key_i) : (idx != 8'd0);
          else drw = 1'b1;
        end
        DEPTH_16: drw = !(mode_i == MODE_TRANSP && src_i == 16'd0);
        default: drw = 1'b0;
      endcase
      plan_o.span[p] = in_rng;
      plan_o.draw[p] = in_rng && drw;
    end
  end

endmodule

// File: sv/bitmap_line_color_expander.sv
// Bitmap line color expander. A start or palette write request is taken on acceptance. A
// data request is accepted and then steps through each pixel position from its start
// position to the end of the source byte or of the line, with one palette RAM lookup per
// pixel through its single read port; the request channel stalls while it does so.
// Pixel commands leave through a read stage and an output register, so a new request is
// taken while results are still waiting to be collected. Depends on blce_pkg, blce_unpack
// and blce_ram.
`include "bitmap_line_color_expander_defines.svh"

module bitmap_line_color_expander import blce_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int COLOR_BITS    = COLOR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [11:0] line_x_i,
  input  logic [11:0] line_y_i,
  input  logic [12:0] pixel_count_i,
  input  logic [15:0] source_word_i,
  input  logic [7:0]  palette_slot_i,
  input  logic [15:0] palette_color_i,
  // Pixel command channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [15:0] pixel_color_o,
  output logic        invert_o,
  output logic        last_of_item_o
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Configuration registers.
  logic [2:0] depth_q;
  logic [1:0] mode_q;
  logic       use_pal_q;
  logic [2:0] offset_q;
  logic [7:0] key_q;

  // Line state.
  logic [12:0] cursor_x_q, cursor_x_d;
  logic [11:0] cursor_y_q, cursor_y_d;
  logic [12:0] pix_left_q, pix_left_d;
  logic [2:0]  sub_pos_q, sub_pos_d;

  // Pixel sequencer.
  logic        seq_busy_q, seq_busy_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  span_q, span_d;
  logic [7:0]  draw_q, draw_d;
  logic [15:0] src_q;

  // Read stage, aligned with the palette read data.
  logic        r_vld_q;
  logic        r_emit_q;
  logic        r_last_q;
  logic        r_oor_q;
  logic [12:0] r_x_q;
  logic [11:0] r_y_q;
  logic [15:0] r_raw_q;

  // Output register.
  logic        out_vld_q;
  logic [12:0] out_x_q;
  logic [11:0] out_y_q;
  logic [15:0] out_color_q;
  logic        out_inv_q;
  logic        out_last_q;

  logic            in_acc;
  logic            out_free;
  logic            r_move;
  logic            issue;
  logic            data_go;
  logic [7:0]      pos_bit;
  logic [7:0]      cur_idx;
  logic [2:0]      start_off;
  plan_t           plan;
  logic            ram_we;
  logic            ram_re;
  logic [COLOR_BITS-1:0] pal_rdata;
  logic [15:0]     color_sel;

  // Handshakes and pipeline flow.
  assign in_stall_o = seq_busy_q;
  assign in_acc     = in_valid_i && !seq_busy_q;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign r_move     = r_vld_q && (!r_emit_q || out_free);
  assign issue      = seq_busy_q && (!r_vld_q || r_move);
  assign data_go    = in_acc && (kind_i == KIND_DATA) && (depth_q <= DEPTH_16) &&
                      (pix_left_q != 13'd0);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DEPTH_1;
      mode_q    <= MODE_WRITE;
      use_pal_q <= 1'b1;
      offset_q  <= 3'd0;
      key_q     <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEPTH:  depth_q   <= cfg_data_i[2:0];
        CFG_MODE:   mode_q    <= cfg_data_i[1:0];
        CFG_USEPAL: use_pal_q <= cfg_data_i[0];
        CFG_OFFSET: offset_q  <= cfg_data_i[2:0];
        CFG_KEY:    key_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Plan of the positions that a data request steps through and draws.
  blce_unpack u_unpack (
    .depth_i    (depth_q),
    .mode_i     (mode_q),
    .use_pal_i  (use_pal_q),
    .key_i      (key_q),
    .sub_pos_i  (sub_pos_q),
    .pix_left_i (pix_left_q),
    .src_i      (source_word_i),
    .plan_o     (plan)
  );

  assign start_off = offset_q & pos_mask(depth_q);
  assign pos_bit   = 8'd1 << pos_q;
  assign cur_idx   = pix_index(src_q[7:0], depth_q, pos_q);

  // Line state and sequencer: loaded by requests, advanced one position per issue.
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    pix_left_d = pix_left_q;
    sub_pos_d  = sub_pos_q;
    seq_busy_d = seq_busy_q;
    pos_d      = pos_q;
    span_d     = span_q;
    draw_d     = draw_q;
    if (in_acc && kind_i == KIND_START) begin
      cursor_x_d = 13'(line_x_i) + 13'(start_off);
      cursor_y_d = line_y_i;
      pix_left_d = pixel_count_i;
      sub_pos_d  = start_off;
    end
    if (data_go) begin
      seq_busy_d = 1'b1;
      pos_d      = plan.first_pos;
      span_d     = plan.span;
      draw_d     = plan.draw;
      if (depth_q <= DEPTH_4) begin
        sub_pos_d = 3'd0;
      end
    end
    if (issue) begin
      cursor_x_d = cursor_x_q + 13'd1;
      pix_left_d = pix_left_q - 13'd1;
      pos_d      = pos_q + 3'd1;
      span_d     = span_q & ~pos_bit;
      draw_d     = draw_q & ~pos_bit;
      seq_busy_d = ((span_q & ~pos_bit) != 8'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      pix_left_q <= '0;
      sub_pos_q  <= '0;
      seq_busy_q <= 1'b0;
      pos_q      <= '0;
      span_q     <= '0;
      draw_q     <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      pix_left_q <= pix_left_d;
      sub_pos_q  <= sub_pos_d;
      seq_busy_q <= seq_busy_d;
      pos_q      <= pos_d;
      span_q     <= span_d;
      draw_q     <= draw_d;
    end
  end

  // Source word of the request being expanded.
  always_ff @(posedge clk_i) begin
    if (data_go) begin
      src_q <= source_word_i;
    end
  end

  // Palette store. Writes happen only on request acceptance and reads only while the
  // sequencer runs, so the two ports never touch the store in the same cycle.
  assign ram_we = in_acc && (kind_i == KIND_PAL) &&
                  ({1'b0, palette_slot_i} < 9'(PALETTE_DEPTH));
  assign ram_re = issue;

  blce_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (palette_slot_i[AW-1:0]),
    .wdata_i (COLOR_BITS'(palette_color_i)),
    .re_i    (ram_re),
    .raddr_i (cur_idx[AW-1:0]),
    .rdata_o (pal_rdata)
  );

  // Read stage: position, raw value and flags travel alongside the palette lookup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q  <= 1'b0;
      r_emit_q <= 1'b0;
      r_last_q <= 1'b0;
    end else if (issue) begin
      r_vld_q  <= 1'b1;
      r_emit_q <= (draw_q & pos_bit) != 8'd0;
      r_last_q <= ((draw_q & pos_bit) != 8'd0) && ((draw_q & ~pos_bit) == 8'd0);
    end else if (r_move) begin
      r_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      r_x_q   <= cursor_x_q;
      r_y_q   <= cursor_y_q;
      r_oor_q <= {1'b0, cur_idx} >= 9'(PALETTE_DEPTH);
      r_raw_q <= (depth_q == DEPTH_16) ? src_q : {8'd0, cur_idx};
    end
  end

  // Color choice: invert commands carry zero, direct values bypass the palette, indexes beyond the palette give zero.
  always_comb begin
    if (depth_q == DEPTH_1 && mode_q == MODE_XOR) begin
      color_sel = 16'd0;
    end else if (depth_q == DEPTH_16 || (depth_q != DEPTH_1 && !use_pal_q)) begin
      color_sel = r_raw_q;
    end else if (r_oor_q) begin
      color_sel = 16'd0;
    end else begin
      color_sel = 16'(pal_rdata);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (r_move && r_emit_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_move && r_emit_q) begin
      out_x_q     <= r_x_q;
      out_y_q     <= r_y_q;
      out_color_q <= color_sel;
      out_inv_q   <= (depth_q == DEPTH_1) && (mode_q == MODE_XOR);
      out_last_q  <= r_last_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_color_o  = out_color_q;
  assign invert_o       = out_inv_q;
  assign last_of_item_o = out_last_q;

  // Checks.
  `BLCE_ASSERT_ALWAYS(a_ram_ports_apart, !(ram_we && ram_re), "palette read and write collide")
  `BLCE_ASSERT(a_busy_has_span, seq_busy_q |-> (span_q != 8'd0), "sequencer busy with no positions")
  `BLCE_ASSERT(a_read_stage_holds, (r_vld_q && !r_move) |=> (r_vld_q && $stable(r_x_q)), "read stage lost")
  `BLCE_ASSERT(a_issue_counts, issue |=> (pix_left_q == $past(pix_left_q) - 13'd1), "pixel count not stepped")

endmodule
